/* design/cbd_pkg.sv */
// Shared constants, character codes and helper functions for the chunked body decoder.
package cbd_pkg;

  localparam int BYTE_W          = 8;
  localparam int OUT_COUNT_W     = 32;
  localparam int SIZE_BITS_DEF   = 32;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int HEX_DIGIT_W     = 4;
  localparam int BLANK_CNT_W     = 4;

  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_F = 8'h46;
  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_F = 8'h66;
  localparam logic [BYTE_W-1:0] HEX_TEN    = 8'd10;

  // One decoded result as it sits in the output registers.
  typedef struct packed {
    logic                   payload_valid;
    logic [BYTE_W-1:0]      payload_byte;
    logic                   body_complete;
    logic [OUT_COUNT_W-1:0] body_byte_count;
    logic                   size_overflow;
  } result_t;

  // Blanks that are dropped at the edges of a size field.
  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  // Hex digit value of a character, case-insensitive; anything else is zero.
  function automatic logic [HEX_DIGIT_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [HEX_DIGIT_W-1:0] d;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = HEX_DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d = HEX_DIGIT_W'(c - CH_LOWER_A + HEX_TEN);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = HEX_DIGIT_W'(c - CH_UPPER_A + HEX_TEN);
    end
    return d;
  endfunction

endpackage

/* design/cbd_if.sv */
// Valid/ready channel interfaces for the body byte input and the decoded result output.
interface cbd_in_if;
  import cbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface cbd_out_if;
  import cbd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   payload_valid;
  logic [BYTE_W-1:0]      payload_byte;
  logic                   body_complete;
  logic [OUT_COUNT_W-1:0] body_byte_count;
  logic                   size_overflow;

  modport source (output valid, output payload_valid, output payload_byte,
                  output body_complete, output body_byte_count, output size_overflow,
                  input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input body_complete, input body_byte_count, input size_overflow,
                output ready);
endinterface

/* design/chunked_body_decoder.sv */
// Top level of the HTTP chunked transfer-coding body decoder.
//
// The decoder takes one raw byte of a chunked message body per request on the
// body channel and returns exactly one result per request on the result
// channel, in order. It sustains one byte per clock cycle while body.ready is
// high: the whole parse of a byte (size line digit, chunk data, trailer line or
// done) is a short combinational update of the parser registers, and the
// result is registered into the output buffer when the byte is accepted. A
// two-entry output buffer (result register plus skid register) lets the body
// channel keep taking bytes while a result waits; body.ready only drops when
// both entries are full. Size lines are read as hexadecimal, ignoring case,
// everything from ';' to the end of the line, and blanks (space, tab, CR) at
// the edges of the number; blanks between digits and any other character
// count as zero digits. A size beyond SIZE_BITS saturates at all ones and sets
// the sticky size_overflow flag. After a nonzero size the next that many bytes
// come out with payload_valid set, then bytes up to LF are skipped. A zero
// size starts the trailer, whose header lines are discarded; an empty line
// (CR allowed) ends the body, body_complete rises and every later byte is
// ignored. body_byte_count is the running payload count, wrapping at COUNT_BITS.
module chunked_body_decoder #(
  parameter int SIZE_BITS  = cbd_pkg::SIZE_BITS_DEF,
  parameter int COUNT_BITS = cbd_pkg::COUNT_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  cbd_in_if.sink    body,
  cbd_out_if.source result
);
  import cbd_pkg::*;

  // Room for a full accumulator shifted by up to sixteen hex digits.
  localparam int WIDE_W  = SIZE_BITS + 64;
  localparam int SHAMT_W = 7;

  typedef enum logic [1:0] {
    PH_SIZE,
    PH_DATA,
    PH_TRAILER,
    PH_DONE
  } phase_t;

  // Parser state.
  phase_t                 phase, phase_next;
  logic [SIZE_BITS-1:0]   size_acc, size_acc_next;
  logic                   seen_ext, seen_ext_next;
  logic                   field_started, field_started_next;
  logic [BLANK_CNT_W-1:0] pending_blanks, pending_blanks_next;
  logic [SIZE_BITS-1:0]   bytes_remaining, bytes_remaining_next;
  logic                   line_has_text, line_has_text_next;
  logic [COUNT_BITS-1:0]  payload_total, payload_total_next;
  logic                   overflow_seen, overflow_seen_next;

  // Output buffer: the result register and a skid register behind it.
  result_t out_q, skid_q, res_next;
  logic    out_valid, skid_valid;

  logic              in_fire, out_fire;
  logic [BYTE_W-1:0] c;
  logic              pv_next;

  // Digit append: the pending interior blanks become zero digits, then the new
  // digit goes in. Any bit shifted past SIZE_BITS means saturation.
  logic [SHAMT_W-1:0] shamt;
  logic [WIDE_W-1:0]  shifted;
  logic               push_ovf;

  assign c        = body.in_byte;
  assign in_fire  = body.valid && body.ready;
  assign out_fire = result.valid && result.ready;
  assign body.ready = !skid_valid;

  assign shamt    = SHAMT_W'({pending_blanks, 2'b00}) + SHAMT_W'(HEX_DIGIT_W);
  assign shifted  = (WIDE_W'(size_acc) << shamt) | WIDE_W'(hex_value(c));
  assign push_ovf = |shifted[WIDE_W-1:SIZE_BITS];

  always_comb begin
    phase_next           = phase;
    size_acc_next        = size_acc;
    seen_ext_next        = seen_ext;
    field_started_next   = field_started;
    pending_blanks_next  = pending_blanks;
    bytes_remaining_next = bytes_remaining;
    line_has_text_next   = line_has_text;
    payload_total_next   = payload_total;
    overflow_seen_next   = overflow_seen;
    pv_next              = 1'b0;

    unique case (phase)
      PH_SIZE: begin
        if (c == CH_LF) begin
          // End of the size line: start the chunk data, or the trailer on zero.
          bytes_remaining_next = size_acc;
          phase_next           = (size_acc == '0) ? PH_TRAILER : PH_DATA;
          line_has_text_next   = 1'b0;
          size_acc_next        = '0;
          seen_ext_next        = 1'b0;
          field_started_next   = 1'b0;
          pending_blanks_next  = '0;
        end else if (seen_ext) begin
          // Inside a chunk extension: nothing counts until LF.
        end else if (c == CH_SEMI) begin
          seen_ext_next = 1'b1;
        end else if (is_blank(c)) begin
          if (field_started && pending_blanks != '1) begin
            pending_blanks_next = pending_blanks + 1'b1;
          end
        end else begin
          field_started_next  = 1'b1;
          pending_blanks_next = '0;
          if (push_ovf) begin
            size_acc_next      = '1;
            overflow_seen_next = 1'b1;
          end else begin
            size_acc_next = shifted[SIZE_BITS-1:0];
          end
        end
      end
      PH_DATA: begin
        if (bytes_remaining != '0) begin
          pv_next              = 1'b1;
          bytes_remaining_next = bytes_remaining - 1'b1;
          payload_total_next   = payload_total + 1'b1;
        end else if (c == CH_LF) begin
          phase_next          = PH_SIZE;
          size_acc_next       = '0;
          seen_ext_next       = 1'b0;
          field_started_next  = 1'b0;
          pending_blanks_next = '0;
        end
      end
      PH_TRAILER: begin
        if (c == CH_LF) begin
          if (!line_has_text) begin
            phase_next = PH_DONE;
          end
          line_has_text_next = 1'b0;
        end else if (c != CH_CR) begin
          line_has_text_next = 1'b1;
        end
      end
      PH_DONE: begin
        // Body complete; bytes are dropped.
      end
      default: begin
      end
    endcase

    res_next.payload_valid   = pv_next;
    res_next.payload_byte    = pv_next ? c : '0;
    res_next.body_complete   = (phase_next == PH_DONE);
    res_next.body_byte_count = OUT_COUNT_W'(payload_total_next);
    res_next.size_overflow   = overflow_seen_next;
  end

  // Parser state and output buffer occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      size_acc        <= '0;
      seen_ext        <= 1'b0;
      field_started   <= 1'b0;
      pending_blanks  <= '0;
      bytes_remaining <= '0;
      line_has_text   <= 1'b0;
      payload_total   <= '0;
      overflow_seen   <= 1'b0;
      out_valid       <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (in_fire) begin
        phase           <= phase_next;
        size_acc        <= size_acc_next;
        seen_ext        <= seen_ext_next;
        field_started   <= field_started_next;
        pending_blanks  <= pending_blanks_next;
        bytes_remaining <= bytes_remaining_next;
        line_has_text   <= line_has_text_next;
        payload_total   <= payload_total_next;
        overflow_seen   <= overflow_seen_next;
      end
      if (in_fire) begin
        if (out_valid && !result.ready) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // Result payload registers; the valid flags above say when they mean something.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_valid && !result.ready) begin
        skid_q <= res_next;
      end else begin
        out_q <= res_next;
      end
    end else if (out_fire && skid_valid) begin
      out_q <= skid_q;
    end
  end

  assign result.valid           = out_valid;
  assign result.payload_valid   = out_q.payload_valid;
  assign result.payload_byte    = out_q.payload_byte;
  assign result.body_complete   = out_q.body_complete;
  assign result.body_byte_count = out_q.body_byte_count;
  assign result.size_overflow   = out_q.size_overflow;

  // The skid register is only ever filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the result register is empty");

  // Once the body is done the parser never leaves that phase.
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |=> (phase == PH_DONE))
    else $error("parser left the done phase");

  // A payload byte is never reported together with the end of the body.
  a_no_payload_when_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_q.payload_valid && out_q.body_complete))
    else $error("payload byte flagged after the body completed");

  // Every accepted chunk data byte advances the payload count by one.
  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_DATA && bytes_remaining != '0) |=>
      (payload_total == COUNT_BITS'($past(payload_total) + 1'b1)))
    else $error("payload count did not advance on a data byte");

endmodule
